@@ rtl/aesbe_pkg.sv @@
// Shared types, constants and byte-level functions for the AES block encrypt core.
// Used by the round stage, the key expansion unit and the top level; no dependencies.
package aesbe_pkg;

  localparam int unsigned MAX_ROUNDS = 14;
  localparam int unsigned NUM_RK     = MAX_ROUNDS + 1;
  localparam int unsigned BLK_W      = 128;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned RK_IDX_W   = $clog2(NUM_RK);
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [RK_IDX_W-1:0] NR_128 = RK_IDX_W'(10);
  localparam logic [RK_IDX_W-1:0] NR_256 = RK_IDX_W'(MAX_ROUNDS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_3    = 3'd4;

  typedef logic [NUM_RK-1:0][BLK_W-1:0] rk_arr_t;

  typedef struct packed {
    logic             vld;
    logic [BLK_W-1:0] blk;
  } stage_t;

  typedef enum logic [1:0] {
    RND_FULL,
    RND_FINAL,
    RND_PASS
  } rnd_kind_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Byte j of the block sits at the top end: byte 0 is bits 127:120
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(c*4 + r) -: 8] = SBOX[s[127 - 8*(((c + r) % 4)*4 + r) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 8*(c*4)     -: 8];
      a1 = s[127 - 8*(c*4 + 1) -: 8];
      a2 = s[127 - 8*(c*4 + 2) -: 8];
      a3 = s[127 - 8*(c*4 + 3) -: 8];
      t[127 - 8*(c*4)     -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[127 - 8*(c*4 + 1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[127 - 8*(c*4 + 2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[127 - 8*(c*4 + 3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return t;
  endfunction

endpackage

@@ rtl/aesbe_round.sv @@
// One registered cipher round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey; or a pass-through.
// Depends on aesbe_pkg for the S-box, the column mix and the stage type.
module aesbe_round (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  aesbe_pkg::rnd_kind_e   kind_i,
  input  logic [127:0]           rk_i,
  input  aesbe_pkg::stage_t      stage_i,
  output aesbe_pkg::stage_t      stage_o
);
  import aesbe_pkg::*;

  logic [127:0] sub_d;
  logic [127:0] blk_d;
  logic         vld_q;
  logic [127:0] blk_q;

  // Round datapath; rounds beyond the active count pass the block through
  always_comb begin
    sub_d = sub_shift(stage_i.blk);
    unique case (kind_i)
      RND_FULL:  blk_d = mix_columns(sub_d) ^ rk_i;
      RND_FINAL: blk_d = sub_d ^ rk_i;
      RND_PASS:  blk_d = stage_i.blk;
      default:   blk_d = stage_i.blk;
    endcase
  end

  // Advance the valid bit with the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= stage_i.vld;
    end
  end

  // Hold the block while stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      blk_q <= blk_d;
    end
  end

  assign stage_o.vld = vld_q;
  assign stage_o.blk = blk_q;

endmodule

@@ rtl/aesbe_key_exp.sv @@
// Iterative key expansion: one 128-bit round key per cycle into the round-key store.
// Depends on aesbe_pkg for sub_word, xtime and the store type.
module aesbe_key_exp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               mode_i,
  input  logic [255:0]       key_i,
  output logic               run_o,
  output aesbe_pkg::rk_arr_t rk_o
);
  import aesbe_pkg::*;

  logic [7:0][31:0]      win_q;
  logic [RK_IDX_W-1:0]   idx_q;
  logic [7:0]            rcon_q;
  logic                  run_q;
  rk_arr_t               rk_q;
  logic [RK_IDX_W-1:0]   nr;
  logic                  use_rot;
  logic [31:0]           t_fn;
  logic [3:0][31:0]      base;
  logic [3:0][31:0]      nw;
  logic [7:0][31:0]      kw;

  // Key words, word 0 from the top of the key
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      kw[i] = key_i[255 - 32*i -: 32];
    end
  end

  // Next four schedule words; window slot 7 is the newest word
  always_comb begin
    nr      = mode_i ? NR_256 : NR_128;
    use_rot = !mode_i || !idx_q[0];
    t_fn    = use_rot ? (sub_word({win_q[7][23:0], win_q[7][31:24]}) ^ {rcon_q, 24'h0})
                      : sub_word(win_q[7]);
    for (int j = 0; j < 4; j++) begin
      base[j] = mode_i ? win_q[j] : win_q[4 + j];
    end
    nw[0] = base[0] ^ t_fn;
    for (int j = 1; j < 4; j++) begin
      nw[j] = base[j] ^ nw[j-1];
    end
  end

  // Sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      idx_q  <= '0;
      rcon_q <= 8'h01;
    end else if (start_i) begin
      run_q  <= 1'b1;
      idx_q  <= mode_i ? RK_IDX_W'(2) : RK_IDX_W'(1);
      rcon_q <= 8'h01;
    end else if (run_q) begin
      idx_q <= idx_q + RK_IDX_W'(1);
      if (use_rot) begin
        rcon_q <= xtime(rcon_q);
      end
      if (idx_q == nr) begin
        run_q <= 1'b0;
      end
    end
  end

  // Load the key words, then fill one round key per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (mode_i) begin
        win_q <= {kw[7], kw[6], kw[5], kw[4], kw[3], kw[2], kw[1], kw[0]};
        rk_q[1] <= {kw[4], kw[5], kw[6], kw[7]};
      end else begin
        win_q <= {kw[3], kw[2], kw[1], kw[0], kw[3], kw[2], kw[1], kw[0]};
      end
      rk_q[0] <= {kw[0], kw[1], kw[2], kw[3]};
    end else if (run_q) begin
      rk_q[idx_q] <= {nw[0], nw[1], nw[2], nw[3]};
      win_q       <= {nw[3], nw[2], nw[1], nw[0], win_q[7], win_q[6], win_q[5], win_q[4]};
    end
  end

  assign run_o = run_q;
  assign rk_o  = rk_q;

endmodule

@@ rtl/aes_block_encrypt_top.sv @@
// Top level of the AES-128/256 block encrypt core: config registers, key expansion, pipeline.
// Depends on aesbe_pkg, aesbe_key_exp and aesbe_round.
//
//  channel | direction | handshake                    | payload
//  s_axis  | in        | s_axis_tvalid/s_axis_tready  | tdata: plain_high, plain_low
//  m_axis  | out       | m_axis_tvalid/m_axis_tready  | tdata: cipher_high, cipher_low
//  cfg     | in        | cfg_we_i                     | cfg_idx_i, cfg_data_i
//
// One item per cycle unless m_axis stalls or the key expansion runs; initial key add plus 14
// round stages for both key sizes, with rounds past the tenth passing through in AES-128 mode.
// Reset and every write to the mode or a key register rerun the key expansion, one round key
// per cycle, with s_axis_tready low meanwhile.
// A stall on m_axis freezes the whole pipeline; no item is lost or repeated.
module aes_block_encrypt_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [127:0]                       s_axis_tdata,  // plain_high, plain_low
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [127:0]                       m_axis_tdata,  // cipher_high, cipher_low
  input  logic                               cfg_we_i,
  input  logic [aesbe_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [aesbe_pkg::WORD_W-1:0]       cfg_data_i
);
  import aesbe_pkg::*;

  logic                       key_mode_q;
  logic [3:0][WORD_W-1:0]     key_q;
  logic                       kick_q;
  logic                       kick_d;
  logic                       run;
  logic                       en;
  rk_arr_t                    rk;
  logic [RK_IDX_W-1:0]        nr;
  stage_t                     st [NUM_RK];
  logic                       s0_vld_q;
  logic [BLK_W-1:0]           s0_blk_q;
  logic [BLK_W-1:0]           blk_in;

  // Configuration registers; any valid write restarts the expansion
  always_comb begin
    kick_d = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY_MODE, REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3: kick_d = 1'b1;
        default: kick_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_mode_q <= 1'b0;
      key_q      <= '0;
      kick_q     <= 1'b1;
    end else begin
      kick_q <= kick_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_KEY_MODE: key_mode_q <= cfg_data_i[0];
          REG_KEY_0:    key_q[0]   <= cfg_data_i;
          REG_KEY_1:    key_q[1]   <= cfg_data_i;
          REG_KEY_2:    key_q[2]   <= cfg_data_i;
          REG_KEY_3:    key_q[3]   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  aesbe_key_exp u_key_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (kick_q),
    .mode_i  (key_mode_q),
    .key_i   ({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .run_o   (run),
    .rk_o    (rk)
  );

  // Pipeline advances unless the output item is held
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !kick_q && !run;

  // Block byte 0 is the top byte of plain_high
  assign blk_in = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

  // Initial key add stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= s_axis_tvalid && s_axis_tready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_blk_q <= blk_in ^ rk[0];
    end
  end

  assign st[0].vld = s0_vld_q;
  assign st[0].blk = s0_blk_q;
  assign nr        = key_mode_q ? NR_256 : NR_128;

  // Round stages
  for (genvar r = 1; r < NUM_RK; r++) begin : g_round
    rnd_kind_e kind;

    always_comb begin
      if (RK_IDX_W'(r) < nr) begin
        kind = RND_FULL;
      end else if (RK_IDX_W'(r) == nr) begin
        kind = RND_FINAL;
      end else begin
        kind = RND_PASS;
      end
    end

    aesbe_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .kind_i  (kind),
      .rk_i    (rk[r]),
      .stage_i (st[r-1]),
      .stage_o (st[r])
    );
  end

  assign m_axis_tvalid = st[NUM_RK-1].vld;
  assign m_axis_tdata  = {st[NUM_RK-1].blk[63:0], st[NUM_RK-1].blk[127:64]};

endmodule

@@ bench/aesbe_checker.sv @@
// Scoreboard for the AES block encrypt core: tracks the key registers, predicts every
// ciphertext and compares it with the output stream. Depends on aesbe_pkg only.
module aesbe_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [127:0]                    s_tdata_i,   // plain_high, plain_low
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [127:0]                    m_tdata_i,   // cipher_high, cipher_low
  input  logic                            cfg_we_i,
  input  logic [aesbe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [aesbe_pkg::WORD_W-1:0]    cfg_data_i,
  output int                              err_count_o,
  output int                              pending_o
);
  import aesbe_pkg::*;

  logic         mode_q;
  logic [63:0]  key_q [4];
  rk_arr_t      sched_q;
  int           rounds_q;
  logic [127:0] cipher_q [$];

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    logic [31:0] r;
    for (int b = 0; b < 4; b++) r[8*b +: 8] = SBOX[w[8*b +: 8]];
    return r;
  endfunction

  // Build the round-key schedule for the current mode and key words
  function automatic rk_arr_t grow_schedule(input logic m, input logic [63:0] k0,
                                            input logic [63:0] k1, input logic [63:0] k2,
                                            input logic [63:0] k3);
    logic [31:0] w [60];
    logic [63:0] kb [4];
    logic [31:0] t;
    logic [7:0]  rc;
    int          nk, nr;
    rk_arr_t     rk;
    kb[0] = k0; kb[1] = k1; kb[2] = k2; kb[3] = k3;
    rc = 8'h01;
    rk = '0;
    nk = m ? 8 : 4;
    nr = m ? 14 : 10;
    for (int i = 0; i < 4 * (nr + 1); i++) begin
      if (i < nk) begin
        w[i] = i[0] ? kb[i >> 1][31:0] : kb[i >> 1][63:32];
      end else begin
        t = w[i-1];
        if (i % nk == 0) begin
          t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
          rc = gf_double(rc);
        end else if (nk > 6 && i % nk == 4) begin
          t = sbox_word(t);
        end
        w[i] = w[i-nk] ^ t;
      end
    end
    for (int r = 0; r <= nr; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    return rk;
  endfunction

  // SubBytes and ShiftRows in one pass; byte j sits at bits 127-8j
  function automatic logic [127:0] sub_rows(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8*(c*4 + r) -: 8] = SBOX[s[127 - 8*(((c + r) % 4)*4 + r) -: 8]];
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32*c -: 8];
      a1 = s[119 - 32*c -: 8];
      a2 = s[111 - 32*c -: 8];
      a3 = s[103 - 32*c -: 8];
      t[127 - 32*c -: 8] = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
      t[119 - 32*c -: 8] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
      t[111 - 32*c -: 8] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
      t[103 - 32*c -: 8] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
    end
    return t;
  endfunction

  // Encrypt one block held as {bytes 0..7, bytes 8..15}
  function automatic logic [127:0] encrypt_block(input logic [127:0] blk);
    logic [127:0] s;
    s = blk ^ sched_q[0];
    for (int r = 1; r < rounds_q; r++) s = mix_cols(sub_rows(s)) ^ sched_q[r];
    return sub_rows(s) ^ sched_q[rounds_q];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [127:0] want, got;
    if (!rst_ni) begin
      mode_q = 1'b0;
      for (int i = 0; i < 4; i++) key_q[i] = '0;
      sched_q = grow_schedule(1'b0, '0, '0, '0, '0);
      rounds_q = 10;
      cipher_q.delete();
      err_count_o = 0;
      pending_o = 0;
    end else begin
      // Compare the output item with the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        got = {m_tdata_i[63:0], m_tdata_i[127:64]};
        if (cipher_q.size() == 0) begin
          err_count_o++;
          if (err_count_o <= 10)
            $display("unexpected output item: cipher_high %h cipher_low %h",
                     got[127:64], got[63:0]);
        end else begin
          want = cipher_q.pop_front();
          if (got[127:64] !== want[127:64]) begin
            err_count_o++;
            if (err_count_o <= 10)
              $display("cipher_high mismatch: expected %h actual %h",
                       want[127:64], got[127:64]);
          end
          if (got[63:0] !== want[63:0]) begin
            err_count_o++;
            if (err_count_o <= 10)
              $display("cipher_low mismatch: expected %h actual %h",
                       want[63:0], got[63:0]);
          end
        end
      end
      // Predict the ciphertext of each accepted input item
      if (s_tvalid_i && s_tready_i)
        cipher_q.push_back(encrypt_block({s_tdata_i[63:0], s_tdata_i[127:64]}));
      // Track register writes and rebuild the schedule
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KEY_MODE: mode_q = cfg_data_i[0];
          REG_KEY_0:    key_q[0] = cfg_data_i;
          REG_KEY_1:    key_q[1] = cfg_data_i;
          REG_KEY_2:    key_q[2] = cfg_data_i;
          REG_KEY_3:    key_q[3] = cfg_data_i;
          default: ;
        endcase
        sched_q = grow_schedule(mode_q, key_q[0], key_q[1], key_q[2], key_q[3]);
        rounds_q = mode_q ? 14 : 10;
      end
      pending_o = cipher_q.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
// Top of the AES block encrypt bench: clock, reset, stimulus, receiver and verdict.
// Depends on aesbe_pkg, aes_block_encrypt_top and aesbe_checker.
module testbench;
  import aesbe_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int IDLE_LIMIT = 5000;

  logic                 clk_i, rst_ni;
  logic                 s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [127:0]         s_axis_tdata, m_axis_tdata;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [WORD_W-1:0]    cfg_data_i;
  int                   err_count, pending;
  int                   send_idle_pct, recv_stall_pct;
  bit                   hold_req;
  int                   quiet_cycles;

  aes_block_encrypt_top dut (.*);

  aesbe_checker u_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .err_count_o(err_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, with one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one plaintext item, optionally after an idle gap, and hold until taken
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(14, 1) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {lo, hi};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Drop valid and wait for the pipeline to drain
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    logic [63:0] kw [4];
    logic [63:0] ph, pl;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_KEY_MODE;
    cfg_data_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset key, extreme blocks
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    drain();
    // Standard AES-128 key
    reg_write(REG_KEY_0, 64'h0001020304050607);
    reg_write(REG_KEY_1, 64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block('0, '1);
    drain();
    // AES-256 with high mode bits set, then the standard key
    reg_write(REG_KEY_MODE, 64'hffff_ffff_ffff_ffff);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    drain();
    reg_write(REG_KEY_2, 64'h1011121314151617);
    reg_write(REG_KEY_3, 64'h18191a1b1c1d1e1f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block('1, '0);
    drain();
    // Writes to unused indexes are ignored
    reg_write(REG_SPARE_LO, '1);
    reg_write(REG_SPARE_HI, '1);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
    drain();
    // Mode back to AES-128, with bit 0 clear but upper bits set
    reg_write(REG_KEY_MODE, 64'hffff_ffff_ffff_fffe);
    send_block('1, '1);
    drain();
    // All-ones key in both modes
    for (int i = 0; i < 4; i++) reg_write(CFG_IDX_W'(REG_KEY_0 + i), '1);
    send_block('0, '0);
    drain();
    reg_write(REG_KEY_MODE, 64'd1);
    send_block('0, '0);
    send_block('1, '1);
    drain();

    // Random phases over several key settings and idling patterns
    for (int p = 0; p < 8; p++) begin
      for (int i = 0; i < 4; i++) kw[i] = rand_word();
      if (p == 2) begin
        // Partial update: one word only
        reg_write(CFG_IDX_W'(REG_KEY_0 + $urandom_range(3)), kw[0]);
      end else begin
        reg_write(REG_KEY_MODE, {$urandom, $urandom});
        for (int i = 0; i < 4; i++) reg_write(CFG_IDX_W'(REG_KEY_0 + i), kw[i]);
        if ($urandom_range(3) == 0) reg_write(CFG_IDX_W'($urandom_range(7, 5)), '1);
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      if (p == 4) hold_req = 1'b1;
      for (int n = 0; n < 54; n++) begin
        ph = rand_word();
        pl = rand_word();
        send_block(ph, pl);
      end
      drain();
    end

    if (err_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
